@@ sv/stk_pkg.sv @@
package stk_pkg;

    localparam int WORD_W = 32;
    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

    typedef enum logic [1:0]
    {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CHECK = 2'd3
    } op_t;

    typedef enum logic [1:0]
    {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_CHK_RD,
        S_CHK_CMP
    } state_t;

    typedef struct packed
    {
        logic [WORD_W-1:0] data;
        status_t           status;
        logic              is_palindrome;
    } result_t;

endpackage

@@ sv/stk_ram.sv @@
module stk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ sv/stk_seq.sv @@
module stk_seq #(
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  stk_pkg::op_t               in_op,
    input  logic [stk_pkg::WORD_W-1:0] in_value,
    input  logic                       slot_free,
    output logic                       post,
    output stk_pkg::result_t           res,
    output logic                       ram_we,
    output logic [AW-1:0]              ram_waddr,
    output logic [stk_pkg::WORD_W-1:0] ram_wdata,
    output logic [AW-1:0]              ram_raddr_a,
    output logic [AW-1:0]              ram_raddr_b,
    input  logic [stk_pkg::WORD_W-1:0] ram_rdata_a,
    input  logic [stk_pkg::WORD_W-1:0] ram_rdata_b
);

    stk_pkg::state_t             state_reg, state_next;
    stk_pkg::op_t                op_reg, op_next;
    logic [stk_pkg::WORD_W-1:0]  value_reg, value_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [AW-1:0]               lo_reg, lo_next;
    logic [AW-1:0]               hi_reg, hi_next;

    logic [CW-1:0]               count_dec;
    logic [AW-1:0]               top_addr;
    logic [AW:0]                 span;
    logic                        full;
    logic                        empty;
    logic                        short_stack;
    logic                        match;
    logic                        last_pair;

    assign count_dec   = count_reg - CW'(1);
    assign top_addr    = count_dec[AW-1:0];
    assign full        = (count_reg == CW'(DEPTH));
    assign empty       = (count_reg == '0);
    assign short_stack = (count_reg < CW'(2));
    assign span        = {1'b0, hi_reg} - {1'b0, lo_reg};
    assign last_pair   = (span <= (AW+1)'(2));
    // single compare unit, one entry pair per pass
    assign match       = (ram_rdata_a == ram_rdata_b);

    assign ram_waddr   = count_reg[AW-1:0];
    assign ram_wdata   = value_reg;
    assign ram_raddr_a = (op_reg == stk_pkg::OP_CHECK) ? lo_reg : top_addr;
    assign ram_raddr_b = hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stk_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        value_reg <= value_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stk_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stk_pkg::S_EXEC;
                end
            end
            stk_pkg::S_EXEC:
            begin
                case (op_reg)
                    stk_pkg::OP_PUSH:
                    begin
                        if (slot_free)
                        begin
                            state_next = stk_pkg::S_IDLE;
                        end
                    end
                    stk_pkg::OP_POP, stk_pkg::OP_PEEK:
                    begin
                        if (!empty)
                        begin
                            state_next = stk_pkg::S_RDWAIT;
                        end
                        else if (slot_free)
                        begin
                            state_next = stk_pkg::S_IDLE;
                        end
                    end
                    stk_pkg::OP_CHECK:
                    begin
                        if (!short_stack)
                        begin
                            state_next = stk_pkg::S_CHK_RD;
                        end
                        else if (slot_free)
                        begin
                            state_next = stk_pkg::S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = stk_pkg::S_IDLE;
                    end
                endcase
            end
            stk_pkg::S_RDWAIT:
            begin
                if (slot_free)
                begin
                    state_next = stk_pkg::S_IDLE;
                end
            end
            stk_pkg::S_CHK_RD:
            begin
                state_next = stk_pkg::S_CHK_CMP;
            end
            stk_pkg::S_CHK_CMP:
            begin
                if (match && !last_pair)
                begin
                    state_next = stk_pkg::S_CHK_RD;
                end
                else if (slot_free)
                begin
                    state_next = stk_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = stk_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready          = (state_reg == stk_pkg::S_IDLE);
        post              = 1'b0;
        res.data          = '0;
        res.status        = stk_pkg::ST_OK;
        res.is_palindrome = 1'b0;
        ram_we            = 1'b0;
        op_next           = op_reg;
        value_next        = value_reg;
        count_next        = count_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        case (state_reg)
            stk_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_op;
                    value_next = in_value;
                end
            end
            stk_pkg::S_EXEC:
            begin
                case (op_reg)
                    stk_pkg::OP_PUSH:
                    begin
                        if (slot_free)
                        begin
                            post = 1'b1;
                            if (full)
                            begin
                                res.status = stk_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                    end
                    stk_pkg::OP_POP, stk_pkg::OP_PEEK:
                    begin
                        if (empty && slot_free)
                        begin
                            post       = 1'b1;
                            res.data   = stk_pkg::EMPTY_WORD;
                            res.status = stk_pkg::ST_EMPTY;
                        end
                    end
                    stk_pkg::OP_CHECK:
                    begin
                        if (short_stack)
                        begin
                            if (slot_free)
                            begin
                                post              = 1'b1;
                                res.is_palindrome = 1'b1;
                            end
                        end
                        else
                        begin
                            lo_next = '0;
                            hi_next = top_addr;
                        end
                    end
                    default:
                    begin
                        post = 1'b0;
                    end
                endcase
            end
            stk_pkg::S_RDWAIT:
            begin
                if (slot_free)
                begin
                    post     = 1'b1;
                    res.data = ram_rdata_a;
                    if (op_reg == stk_pkg::OP_POP)
                    begin
                        count_next = count_dec;
                    end
                end
            end
            stk_pkg::S_CHK_CMP:
            begin
                if (match && !last_pair)
                begin
                    lo_next = lo_reg + AW'(1);
                    hi_next = hi_reg - AW'(1);
                end
                else if (slot_free)
                begin
                    post              = 1'b1;
                    res.is_palindrome = match;
                end
            end
            default:
            begin
                post = 1'b0;
            end
        endcase
    end

endmodule

@@ sv/stack_with_palindrome_check.sv @@
// lifo stack of signed 32-bit words with a palindrome check
// input beat: s_axis_tuser carries the op (0 push, 1 pop, 2 peek, 3 check),
// s_axis_tdata the word to push; every accepted beat gives one output beat
// output beat: m_axis_tdata holds the popped or peeked word (all ones when
// empty), m_axis_tuser the status (0 ok, 1 full, 2 empty) and palindrome flag
// steps after acceptance: push, and pop or peek on an empty stack, post from
// exec; pop or peek post from a read wait after exec; check posts from exec
// on fewer than two entries, else reads then compares up to DEPTH/2 pairs
// one item at a time: the next beat can be taken in the cycle after the
// result is posted
// the check runs on one compare unit fed by the two read ports of the entry
// ram, each pair needing a read step and a compare step
// the result sits in an output register; a stall there holds the sequencer
// in its last step until the register frees up
// reset empties the stack; entry ram contents are not cleared
module stack_with_palindrome_check #(
    parameter int DEPTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value[31:0]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // data[31:0]
    output logic [2:0]  m_axis_tuser    // status[1:0], is_palindrome[2]
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                       slot_free;
    logic                       post;
    stk_pkg::result_t           res;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [stk_pkg::WORD_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr_a;
    logic [AW-1:0]              ram_raddr_b;
    logic [stk_pkg::WORD_W-1:0] ram_rdata_a;
    logic [stk_pkg::WORD_W-1:0] ram_rdata_b;

    logic                       m_valid_reg, m_valid_next;
    stk_pkg::result_t           m_res_reg;

    assign slot_free = !m_valid_reg || m_axis_tready;

    stk_seq #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_op       (stk_pkg::op_t'(s_axis_tuser)),
        .in_value    (s_axis_tdata),
        .slot_free   (slot_free),
        .post        (post),
        .res         (res),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr_a (ram_raddr_a),
        .ram_raddr_b (ram_raddr_b),
        .ram_rdata_a (ram_rdata_a),
        .ram_rdata_b (ram_rdata_b)
    );

    stk_ram #(
        .WIDTH (stk_pkg::WORD_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (post)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (post)
        begin
            m_res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_res_reg.data;
    assign m_axis_tuser  = {m_res_reg.is_palindrome, m_res_reg.status};

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready
    ) else $error("input taken while an item is in progress");

    a_empty_word: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[1:0] == stk_pkg::ST_EMPTY))
            |-> (m_axis_tdata == stk_pkg::EMPTY_WORD)
    ) else $error("empty status without all-ones data");

    a_pal_status_ok: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tuser[1:0] == stk_pkg::ST_OK)
    ) else $error("palindrome flag with non-ok status");
`endif

endmodule
